FILE: sv/assert_macros.svh
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication check failed");

// implication a fixed number of cycles later
`define ASSERT_DELAYED(lbl, clk, rst, pre, n, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> ##n (post)) \
      else $error("delayed check failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, pre, post)
`define ASSERT_DELAYED(lbl, clk, rst, pre, n, post)

`endif

`endif

FILE: sv/v3alu_pkg.sv
package v3alu_pkg;

   // width of every vector component and scalar
   localparam int WORD_BITS = 32;

   // operation codes
   typedef enum logic [3:0] {
      CMD_ADD   = 4'd0,
      CMD_SUB   = 4'd1,
      CMD_MUL   = 4'd2,
      CMD_DIV   = 4'd3,
      CMD_SCALE = 4'd4,
      CMD_SDIV  = 4'd5,
      CMD_CROSS = 4'd6,
      CMD_DOT   = 4'd7,
      CMD_LEN   = 4'd8,
      CMD_LENSQ = 4'd9,
      CMD_NORM  = 4'd10
   } cmd_type;

   // request payload
   typedef struct packed {
      logic [3:0]                  command;
      logic signed [WORD_BITS-1:0] ax;
      logic signed [WORD_BITS-1:0] ay;
      logic signed [WORD_BITS-1:0] az;
      logic signed [WORD_BITS-1:0] bx;
      logic signed [WORD_BITS-1:0] by;
      logic signed [WORD_BITS-1:0] bz;
      logic signed [WORD_BITS-1:0] scalar;
   } req_type;

   // result payload
   typedef struct packed {
      logic signed [WORD_BITS-1:0] rx;
      logic signed [WORD_BITS-1:0] ry;
      logic signed [WORD_BITS-1:0] rz;
      logic signed [WORD_BITS-1:0] rs;
      logic                        saturated;
      logic                        div_by_zero;
   } rsp_type;

endpackage

FILE: sv/v3alu_sqrt.sv
// Pipelined integer square root, one result bit per stage, rounded to nearest.
module v3alu_sqrt #(
   parameter int ROOT_BITS = 32
) (
   input  logic                     clock,
   input  logic [2*ROOT_BITS-1:0]   rad_in,
   output logic [ROOT_BITS:0]       root_out
);

   localparam int RemBits = ROOT_BITS + 2;

   logic [RemBits-1:0]     rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0]   root_ff [ROOT_BITS];
   logic [2*ROOT_BITS-1:0] rad_ff  [ROOT_BITS];
   logic [ROOT_BITS:0]     root_out_ff;
   logic                   round_up;

   // one digit pair of the radicand per stage
   for (genvar g = 0; g < ROOT_BITS; g++) begin : g_step
      logic [RemBits-1:0]     rem_prev;
      logic [ROOT_BITS-1:0]   root_prev;
      logic [2*ROOT_BITS-1:0] rad_prev;
      logic [RemBits+1:0]     rem_sh;
      logic [RemBits+1:0]     trial;
      logic [RemBits+1:0]     diff;
      logic                   take;

      if (g == 0) begin : g_head
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = rad_in;
      end else begin : g_body
         assign rem_prev  = rem_ff[g-1];
         assign root_prev = root_ff[g-1];
         assign rad_prev  = rad_ff[g-1];
      end

      assign rem_sh = {rem_prev, rad_prev[2*ROOT_BITS-1 -: 2]};
      assign trial  = {2'b00, root_prev, 2'b01};
      assign diff   = rem_sh - trial;
      assign take   = rem_sh >= trial;

      always_ff @(posedge clock) begin
         rem_ff[g]  <= take ? diff[RemBits-1:0] : rem_sh[RemBits-1:0];
         root_ff[g] <= {root_prev[ROOT_BITS-2:0], take};
         rad_ff[g]  <= {rad_prev[2*ROOT_BITS-3:0], 2'b00};
      end
   end

   // round up when the remainder exceeds the floor root
   assign round_up = rem_ff[ROOT_BITS-1] > RemBits'(root_ff[ROOT_BITS-1]);

   always_ff @(posedge clock) begin
      root_out_ff <= {1'b0, root_ff[ROOT_BITS-1]} + {{ROOT_BITS{1'b0}}, round_up};
   end

   assign root_out = root_out_ff;

endmodule

FILE: sv/v3alu_div.sv
// Pipelined restoring divider on magnitudes: (num << FRAC_BITS) / den,
// one quotient bit per stage, rounded to nearest with ties away from zero.
module v3alu_div #(
   parameter int NUM_BITS  = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic [NUM_BITS-1:0]           num_in,
   input  logic [NUM_BITS:0]             den_in,
   output logic [NUM_BITS+FRAC_BITS:0]   quo_out
);

   localparam int QuoBits = NUM_BITS + FRAC_BITS;

   logic [NUM_BITS:0]  rem_ff [QuoBits];
   logic [QuoBits-1:0] nq_ff  [QuoBits];
   logic [NUM_BITS:0]  den_ff [QuoBits];
   logic [QuoBits:0]   quo_out_ff;
   logic               round_up;

   // numerator bits leave at the top while quotient bits enter at the bottom
   for (genvar g = 0; g < QuoBits; g++) begin : g_step
      logic [NUM_BITS:0]   rem_prev;
      logic [QuoBits-1:0]  nq_prev;
      logic [NUM_BITS:0]   den_prev;
      logic [NUM_BITS+1:0] rem_sh;
      logic [NUM_BITS+1:0] den_ext;
      logic [NUM_BITS+1:0] diff;
      logic                take;

      if (g == 0) begin : g_head
         assign rem_prev = '0;
         assign nq_prev  = {num_in, {FRAC_BITS{1'b0}}};
         assign den_prev = den_in;
      end else begin : g_body
         assign rem_prev = rem_ff[g-1];
         assign nq_prev  = nq_ff[g-1];
         assign den_prev = den_ff[g-1];
      end

      assign rem_sh  = {rem_prev, nq_prev[QuoBits-1]};
      assign den_ext = {1'b0, den_prev};
      assign diff    = rem_sh - den_ext;
      assign take    = rem_sh >= den_ext;

      always_ff @(posedge clock) begin
         rem_ff[g] <= take ? diff[NUM_BITS:0] : rem_sh[NUM_BITS:0];
         nq_ff[g]  <= {nq_prev[QuoBits-2:0], take};
         den_ff[g] <= den_prev;
      end
   end

   // half or more of the divisor left over rounds up
   assign round_up = {rem_ff[QuoBits-1], 1'b0} >= {1'b0, den_ff[QuoBits-1]};

   always_ff @(posedge clock) begin
      quo_out_ff <= {1'b0, nq_ff[QuoBits-1]} + {{QuoBits{1'b0}}, round_up};
   end

   assign quo_out = quo_out_ff;

endmodule

FILE: sv/vector3_fixed_point_alu.sv
`include "assert_macros.svh"
// Three-component fixed-point vector unit (signed Q(32-FRAC_BITS).FRAC_BITS).
// A request is taken on every clock edge where start is high; busy never rises,
// so one request per cycle is sustained. Every command, simple or not, goes
// through the same pipeline and its result appears on rsp_payload with
// rsp_strobe high, in request order; the default format is Q16.16. The
// latency is set by the square root pipeline (one root bit per stage) followed
// by the divider pipeline (one quotient bit per stage) that normalise needs.
// The result is shown for one cycle only and must be captured then. Overflow
// saturates and sets saturated; a zero divisor gives full scale with the
// dividend's sign and sets div_by_zero.
module vector3_fixed_point_alu
   import v3alu_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   localparam int W       = WORD_BITS;
   localparam int PW      = 2 * W;
   localparam int SW      = 2 * W + 2;
   localparam int QW      = W + FRAC_BITS + 1;
   localparam int SQ_LAT  = W + 1;
   localparam int DIV_LAT = W + FRAC_BITS + 1;
   localparam int LAT     = 2 * W + FRAC_BITS + 7;

   localparam logic [W-1:0] WMAX_U = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] WMIN_U = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [SW-1:0] SMAX = $signed({{(SW-W){1'b0}}, WMAX_U});
   localparam logic signed [SW-1:0] SMIN = $signed({{(SW-W){1'b1}}, WMIN_U});
   localparam logic signed [SW-1:0] HALF =
      $signed({{(SW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}});

   // sideband through the square root pipeline
   typedef struct packed {
      logic                valid;
      cmd_type             cmd;
      logic [2:0][W-1:0]   r;
      logic [W-1:0]        rs;
      logic                sat;
      logic [2:0][W-1:0]   anum;
      logic [2:0][W-1:0]   dmag;
      logic [2:0]          aneg;
      logic [2:0]          azero;
      logic [2:0]          dzero;
      logic [2:0]          qneg;
      logic                sq_zero;
   } mid_type;

   // sideband through the divider pipeline
   typedef struct packed {
      logic                valid;
      cmd_type             cmd;
      logic [2:0][W-1:0]   r;
      logic [W-1:0]        rs;
      logic                sat;
      logic [2:0]          aneg;
      logic [2:0]          azero;
      logic [2:0]          dzero;
      logic [2:0]          qneg;
      logic                sq_zero;
   } tail_type;

   // rounding of a double-width sum to nearest, ties upward, then clamp
   function automatic logic [W:0] round_sat(input logic signed [SW-1:0] t);
      logic signed [SW-1:0] u;
      u = (t + HALF) >>> FRAC_BITS;
      if (u > SMAX) begin
         round_sat = {1'b1, WMAX_U};
      end else if (u < SMIN) begin
         round_sat = {1'b1, WMIN_U};
      end else begin
         round_sat = {1'b0, u[W-1:0]};
      end
   endfunction

   // clamp of a one-bit-wider sum
   function automatic logic [W:0] sat_sum(input logic signed [W:0] x);
      if (x > $signed({1'b0, WMAX_U})) begin
         sat_sum = {1'b1, WMAX_U};
      end else if (x < $signed({1'b1, WMIN_U})) begin
         sat_sum = {1'b1, WMIN_U};
      end else begin
         sat_sum = {1'b0, x[W-1:0]};
      end
   endfunction

   function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
      mag = v[W-1] ? (~$unsigned(v) + 1'b1) : $unsigned(v);
   endfunction

   // ---------------------------------------------------------------
   // Request register
   logic    accept;
   logic    v_a_ff;
   req_type req_a_ff;
   logic signed [W-1:0] a_a [3];
   logic signed [W-1:0] b_a [3];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
      end else begin
         v_a_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_a_ff <= req_payload;
      end
   end

   assign a_a[0] = req_a_ff.ax;
   assign a_a[1] = req_a_ff.ay;
   assign a_a[2] = req_a_ff.az;
   assign b_a[0] = req_a_ff.bx;
   assign b_a[1] = req_a_ff.by;
   assign b_a[2] = req_a_ff.bz;

   // ---------------------------------------------------------------
   // Products stage
   logic                 v_b_ff;
   cmd_type              cmd_b_ff;
   logic signed [W-1:0]  a_b_ff [3];
   logic signed [W-1:0]  b_b_ff [3];
   logic signed [W-1:0]  s_b_ff;
   logic signed [PW-1:0] m_b_ff [3];
   logic signed [PW-1:0] cp_b_ff [3];
   logic signed [PW-1:0] cn_b_ff [3];
   logic signed [PW-1:0] q_b_ff [3];
   logic signed [PW-1:0] m_in [3];
   logic signed [PW-1:0] cp_in [3];
   logic signed [PW-1:0] cn_in [3];
   logic signed [PW-1:0] q_in [3];
   logic signed [W-1:0]  mop [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mop[i]   = (req_a_ff.command == CMD_SCALE) ? req_a_ff.scalar : b_a[i];
         m_in[i]  = a_a[i] * mop[i];
         cp_in[i] = a_a[(i + 1) % 3] * b_a[(i + 2) % 3];
         cn_in[i] = a_a[(i + 2) % 3] * b_a[(i + 1) % 3];
         q_in[i]  = a_a[i] * a_a[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_b_ff <= 1'b0;
      end else begin
         v_b_ff <= v_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd_b_ff <= cmd_type'(req_a_ff.command);
      s_b_ff   <= req_a_ff.scalar;
      for (int i = 0; i < 3; i++) begin
         a_b_ff[i]  <= a_a[i];
         b_b_ff[i]  <= b_a[i];
         m_b_ff[i]  <= m_in[i];
         cp_b_ff[i] <= cp_in[i];
         cn_b_ff[i] <= cn_in[i];
         q_b_ff[i]  <= q_in[i];
      end
   end

   // ---------------------------------------------------------------
   // Sums stage
   logic                 v_c_ff;
   cmd_type              cmd_c_ff;
   logic signed [W-1:0]  a_c_ff [3];
   logic signed [W-1:0]  b_c_ff [3];
   logic signed [W-1:0]  s_c_ff;
   logic signed [SW-1:0] lane_c_ff [3];
   logic signed [SW-1:0] scal_c_ff;
   logic signed [W:0]    sum_c_ff [3];
   logic [PW-1:0]        sq_c_ff;
   logic signed [SW-1:0] lane_in [3];
   logic signed [SW-1:0] scal_in;
   logic signed [W:0]    sum_in [3];
   logic [PW-1:0]        sq_in;

   always_comb begin
      sq_in = $unsigned(q_b_ff[0]) + $unsigned(q_b_ff[1]) + $unsigned(q_b_ff[2]);
      if (cmd_b_ff == CMD_LENSQ) begin
         scal_in = $signed({2'b00, sq_in});
      end else begin
         scal_in = SW'(m_b_ff[0]) + SW'(m_b_ff[1]) + SW'(m_b_ff[2]);
      end
      for (int i = 0; i < 3; i++) begin
         if (cmd_b_ff == CMD_CROSS) begin
            lane_in[i] = SW'(cp_b_ff[i]) - SW'(cn_b_ff[i]);
         end else begin
            lane_in[i] = SW'(m_b_ff[i]);
         end
         if (cmd_b_ff == CMD_SUB) begin
            sum_in[i] = (W+1)'(a_b_ff[i]) - (W+1)'(b_b_ff[i]);
         end else begin
            sum_in[i] = (W+1)'(a_b_ff[i]) + (W+1)'(b_b_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_c_ff <= 1'b0;
      end else begin
         v_c_ff <= v_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      cmd_c_ff  <= cmd_b_ff;
      s_c_ff    <= s_b_ff;
      scal_c_ff <= scal_in;
      sq_c_ff   <= sq_in;
      for (int i = 0; i < 3; i++) begin
         a_c_ff[i]    <= a_b_ff[i];
         b_c_ff[i]    <= b_b_ff[i];
         lane_c_ff[i] <= lane_in[i];
         sum_c_ff[i]  <= sum_in[i];
      end
   end

   // ---------------------------------------------------------------
   // Round and clamp stage; prepares operands for root and divider
   mid_type             mid_in;
   logic [W:0]          rsv [3];
   logic [W:0]          srsv;
   logic [2:0]          lsat;
   logic signed [W-1:0] dsel [3];
   logic [PW-1:0]       sq_d_ff;

   always_comb begin
      mid_in         = '0;
      mid_in.valid   = v_c_ff;
      mid_in.cmd     = cmd_c_ff;
      mid_in.sq_zero = (sq_c_ff == '0);
      srsv           = round_sat(scal_c_ff);
      lsat           = '0;
      for (int i = 0; i < 3; i++) begin
         dsel[i]            = (cmd_c_ff == CMD_SDIV) ? s_c_ff : b_c_ff[i];
         mid_in.anum[i]     = mag(a_c_ff[i]);
         mid_in.aneg[i]     = a_c_ff[i][W-1];
         mid_in.azero[i]    = (a_c_ff[i] == '0);
         mid_in.dmag[i]     = mag(dsel[i]);
         mid_in.dzero[i]    = (dsel[i] == '0);
         mid_in.qneg[i]     = (cmd_c_ff == CMD_NORM) ? a_c_ff[i][W-1]
                                                    : (a_c_ff[i][W-1] ^ dsel[i][W-1]);
         if ((cmd_c_ff == CMD_ADD) || (cmd_c_ff == CMD_SUB)) begin
            rsv[i] = sat_sum(sum_c_ff[i]);
         end else begin
            rsv[i] = round_sat(lane_c_ff[i]);
         end
      end
      unique case (cmd_c_ff)
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_SCALE, CMD_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               mid_in.r[i] = rsv[i][W-1:0];
               lsat[i]     = rsv[i][W];
            end
         end
         CMD_DOT, CMD_LENSQ: begin
            mid_in.rs = srsv[W-1:0];
            lsat[0]   = srsv[W];
         end
         default: begin
         end
      endcase
      mid_in.sat = |lsat;
   end

   always_ff @(posedge clock) begin
      sq_d_ff <= sq_c_ff;
   end

   // ---------------------------------------------------------------
   // Square root and its sideband
   mid_type    mid_ff [SQ_LAT+1];
   mid_type    mid_o;
   logic [W:0] root;

   v3alu_sqrt #(
      .ROOT_BITS (W)
   ) u_sqrt (
      .clock    (clock),
      .rad_in   (sq_d_ff),
      .root_out (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SQ_LAT; k++) begin
            mid_ff[k] <= '0;
         end
      end else begin
         mid_ff[0] <= mid_in;
         for (int k = 1; k <= SQ_LAT; k++) begin
            mid_ff[k] <= mid_ff[k-1];
         end
      end
   end

   assign mid_o = mid_ff[SQ_LAT];

   // ---------------------------------------------------------------
   // Length result and divider operands
   tail_type      tail_in;
   logic [W-1:0]  num [3];
   logic [W:0]    den [3];
   logic [QW-1:0] quo [3];

   always_comb begin
      tail_in.valid   = mid_o.valid;
      tail_in.cmd     = mid_o.cmd;
      tail_in.r       = mid_o.r;
      tail_in.rs      = mid_o.rs;
      tail_in.sat     = mid_o.sat;
      tail_in.aneg    = mid_o.aneg;
      tail_in.azero   = mid_o.azero;
      tail_in.dzero   = mid_o.dzero;
      tail_in.qneg    = mid_o.qneg;
      tail_in.sq_zero = mid_o.sq_zero;
      if (mid_o.cmd == CMD_LEN) begin
         if (root > {1'b0, WMAX_U}) begin
            tail_in.rs  = WMAX_U;
            tail_in.sat = 1'b1;
         end else begin
            tail_in.rs  = root[W-1:0];
         end
      end
      for (int i = 0; i < 3; i++) begin
         num[i] = mid_o.anum[i];
         den[i] = (mid_o.cmd == CMD_NORM) ? root : {1'b0, mid_o.dmag[i]};
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      v3alu_div #(
         .NUM_BITS  (W),
         .FRAC_BITS (FRAC_BITS)
      ) u_div (
         .clock   (clock),
         .num_in  (num[l]),
         .den_in  (den[l]),
         .quo_out (quo[l])
      );
   end

   tail_type tail_ff [DIV_LAT];
   tail_type tl;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) begin
            tail_ff[k] <= '0;
         end
      end else begin
         tail_ff[0] <= tail_in;
         for (int k = 1; k < DIV_LAT; k++) begin
            tail_ff[k] <= tail_ff[k-1];
         end
      end
   end

   assign tl = tail_ff[DIV_LAT-1];

   // ---------------------------------------------------------------
   // Quotient sign, clamp and zero-divisor handling; result select
   rsp_type       rsp_in;
   logic [W-1:0]  res_v [3];
   logic [2:0]    qsat;
   logic [2:0]    qdz;
   logic [QW-1:0] negq [3];
   logic          is_div;

   always_comb begin
      is_div = (tl.cmd == CMD_DIV) || (tl.cmd == CMD_SDIV);
      qsat   = '0;
      qdz    = '0;
      for (int i = 0; i < 3; i++) begin
         negq[i]  = ~quo[i] + 1'b1;
         res_v[i] = tl.r[i];
         if (is_div || (tl.cmd == CMD_NORM)) begin
            if (is_div && tl.dzero[i]) begin
               qdz[i] = 1'b1;
               if (tl.azero[i]) begin
                  res_v[i] = '0;
               end else if (tl.aneg[i]) begin
                  res_v[i] = WMIN_U;
               end else begin
                  res_v[i] = WMAX_U;
               end
            end else if ((tl.cmd == CMD_NORM) && tl.sq_zero) begin
               res_v[i] = '0;
            end else if (!tl.qneg[i]) begin
               if (quo[i] > QW'(WMAX_U)) begin
                  res_v[i] = WMAX_U;
                  qsat[i]  = 1'b1;
               end else begin
                  res_v[i] = quo[i][W-1:0];
               end
            end else begin
               if (quo[i] > QW'(WMIN_U)) begin
                  res_v[i] = WMIN_U;
                  qsat[i]  = 1'b1;
               end else begin
                  res_v[i] = negq[i][W-1:0];
               end
            end
         end
      end
      rsp_in.rx          = res_v[0];
      rsp_in.ry          = res_v[1];
      rsp_in.rz          = res_v[2];
      rsp_in.rs          = tl.rs;
      rsp_in.saturated   = tl.sat | (|qsat);
      rsp_in.div_by_zero = |qdz;
   end

   // ---------------------------------------------------------------
   // Result register
   logic    rsp_strobe_ff;
   rsp_type rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= tl.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------------------------------------------------------
   // Checks
   logic acc_non_div;
   logic acc_scalar;
   logic vec_zero;

   assign acc_non_div = accept && (req_payload.command != CMD_DIV)
                        && (req_payload.command != CMD_SDIV);
   assign acc_scalar  = accept && ((req_payload.command == CMD_DOT)
                        || (req_payload.command == CMD_LEN)
                        || (req_payload.command == CMD_LENSQ));
   assign vec_zero    = (rsp_payload.rx == '0) && (rsp_payload.ry == '0)
                        && (rsp_payload.rz == '0);

   `ASSERT_DELAYED(a_fixed_latency, clock, reset, accept, LAT, rsp_strobe)
   `ASSERT_IMPLIES(a_no_spurious, clock, reset, rsp_strobe, $past(accept, LAT))
   `ASSERT_DELAYED(a_dz_only_div, clock, reset, acc_non_div, LAT, !rsp_payload.div_by_zero)
   `ASSERT_DELAYED(a_scalar_zero_vec, clock, reset, acc_scalar, LAT, vec_zero)

endmodule

FILE: bench/vector3_alu_checker.sv
`timescale 1ns / 1ps

// Watches both channels, predicts each result and compares it field by field
module vector3_alu_checker
   import v3alu_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_payload,
   input  logic    rsp_strobe,
   input  rsp_type rsp_payload,
   output int      errors,
   output int      pending
);

   typedef logic signed [127:0] wide_type;
   typedef logic [127:0]        uwide_type;

   localparam wide_type WORD_MAX = (wide_type'(1) <<< (WORD_BITS - 1)) - 1;
   localparam wide_type WORD_MIN = -(wide_type'(1) <<< (WORD_BITS - 1));

   rsp_type expected_results[$];
   bit      clamp_seen;
   bit      zero_div_seen;

   // clamp to the word range, noting any clamp
   function automatic logic signed [WORD_BITS-1:0] clamp_word(input wide_type v);
      if (v > WORD_MAX) begin
         clamp_seen = 1'b1;
         return WORD_MAX[WORD_BITS-1:0];
      end
      if (v < WORD_MIN) begin
         clamp_seen = 1'b1;
         return WORD_MIN[WORD_BITS-1:0];
      end
      return v[WORD_BITS-1:0];
   endfunction

   // drop the fraction bits, nearest with ties upward
   function automatic wide_type round_prod(input wide_type v);
      return (v + (wide_type'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
   endfunction

   // quotient with nonzero divisor magnitude, ties away from zero
   function automatic logic signed [WORD_BITS-1:0] quotient(input wide_type n,
                                                            input bit dneg,
                                                            input uwide_type ud);
      uwide_type un, num, q, r;
      wide_type  sq;
      un  = (n < 0) ? uwide_type'(-n) : uwide_type'(n);
      num = un << FRAC_BITS;
      q   = num / ud;
      r   = num % ud;
      if (2 * r >= ud) q = q + 1;
      sq = wide_type'(q);
      if ((n < 0) != dneg) sq = -sq;
      return clamp_word(sq);
   endfunction

   function automatic logic signed [WORD_BITS-1:0] divide(input wide_type n,
                                                          input wide_type d);
      if (d == 0) begin
         zero_div_seen = 1'b1;
         if (n > 0) return WORD_MAX[WORD_BITS-1:0];
         if (n < 0) return WORD_MIN[WORD_BITS-1:0];
         return '0;
      end
      return quotient(n, d < 0, (d < 0) ? uwide_type'(-d) : uwide_type'(d));
   endfunction

   // rounded square root of a sum of squares
   function automatic uwide_type root_round(input uwide_type s);
      uwide_type res, cand;
      res = '0;
      for (int b = 49; b >= 0; b--) begin
         cand = res | (uwide_type'(1) << b);
         if (cand * cand <= s) res = cand;
      end
      if (s - res * res > res) res = res + 1;
      return res;
   endfunction

   function automatic rsp_type predict_vector_op(input req_type rq);
      rsp_type   res;
      wide_type  a[3], b[3], s, t;
      uwide_type sumsq, len;
      int        j, k;
      res = '0;
      clamp_seen = 1'b0;
      zero_div_seen = 1'b0;
      a[0] = wide_type'(rq.ax); a[1] = wide_type'(rq.ay); a[2] = wide_type'(rq.az);
      b[0] = wide_type'(rq.bx); b[1] = wide_type'(rq.by); b[2] = wide_type'(rq.bz);
      s = wide_type'(rq.scalar);
      sumsq = uwide_type'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      // vector lane i sits at rx, ry, rz from the top of the payload down
      unique case (rq.command)
         CMD_ADD: for (int i = 0; i < 3; i++) res[4*WORD_BITS+1 - i*WORD_BITS -: WORD_BITS] =
            clamp_word(a[i] + b[i]);
         CMD_SUB: for (int i = 0; i < 3; i++) res[4*WORD_BITS+1 - i*WORD_BITS -: WORD_BITS] =
            clamp_word(a[i] - b[i]);
         CMD_MUL: for (int i = 0; i < 3; i++) res[4*WORD_BITS+1 - i*WORD_BITS -: WORD_BITS] =
            clamp_word(round_prod(a[i] * b[i]));
         CMD_DIV: for (int i = 0; i < 3; i++) res[4*WORD_BITS+1 - i*WORD_BITS -: WORD_BITS] =
            divide(a[i], b[i]);
         CMD_SCALE: for (int i = 0; i < 3; i++) res[4*WORD_BITS+1 - i*WORD_BITS -: WORD_BITS] =
            clamp_word(round_prod(a[i] * s));
         CMD_SDIV: for (int i = 0; i < 3; i++) res[4*WORD_BITS+1 - i*WORD_BITS -: WORD_BITS] =
            divide(a[i], s);
         CMD_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               j = (i + 1) % 3;
               k = (i + 2) % 3;
               t = a[j] * b[k] - a[k] * b[j];
               res[4*WORD_BITS+1 - i*WORD_BITS -: WORD_BITS] = clamp_word(round_prod(t));
            end
         end
         CMD_DOT: res.rs = clamp_word(round_prod(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]));
         CMD_LEN: begin
            len = root_round(sumsq);
            if (len > uwide_type'(WORD_MAX)) begin
               clamp_seen = 1'b1;
               res.rs = WORD_MAX[WORD_BITS-1:0];
            end else begin
               res.rs = len[WORD_BITS-1:0];
            end
         end
         CMD_LENSQ: res.rs = clamp_word(round_prod(wide_type'(sumsq)));
         CMD_NORM: begin
            // zero vector stays zero with no flag
            if (sumsq != 0) begin
               len = root_round(sumsq);
               for (int i = 0; i < 3; i++)
                  res[4*WORD_BITS+1 - i*WORD_BITS -: WORD_BITS] = quotient(a[i], 1'b0, len);
            end
         end
         default: ;
      endcase
      res.saturated = clamp_seen;
      res.div_by_zero = zero_div_seen;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: result mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      errors++;
   endtask

   // results are compared before new requests are queued; latency keeps them apart
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_results.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with no request outstanding", $realtime);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.rx !== want.rx) report_mismatch("rx", rsp_payload.rx, want.rx);
               if (rsp_payload.ry !== want.ry) report_mismatch("ry", rsp_payload.ry, want.ry);
               if (rsp_payload.rz !== want.rz) report_mismatch("rz", rsp_payload.rz, want.rz);
               if (rsp_payload.rs !== want.rs) report_mismatch("rs", rsp_payload.rs, want.rs);
               if (rsp_payload.saturated !== want.saturated)
                  report_mismatch("saturated", rsp_payload.saturated, want.saturated);
               if (rsp_payload.div_by_zero !== want.div_by_zero)
                  report_mismatch("div_by_zero", rsp_payload.div_by_zero, want.div_by_zero);
            end
         end
         if (start && !busy) expected_results.push_back(predict_vector_op(req_payload));
      end
      pending = expected_results.size();
   end

   initial begin
      errors = 0;
      pending = 0;
   end

endmodule

FILE: bench/tb_vector3_fixed_point_alu.sv
`timescale 1ns / 1ps

module tb_vector3_fixed_point_alu;
   import v3alu_pkg::*;

   localparam int LATENCY     = 87;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_REQS = 700;

   localparam logic [31:0] ONE   = 32'h0001_0000;
   localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
   localparam logic [31:0] Q_MIN = 32'h8000_0000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   int      errors;
   int      pending;
   int      cycles;
   int      cmd_count[16];
   int      sent;

   vector3_fixed_point_alu dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload)
   );

   vector3_alu_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .errors(errors), .pending(pending)
   );

   always #2 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // hold a request until the block takes it
   task automatic issue(input req_type rq);
      bit taken;
      @(negedge clock);
      start <= 1'b1;
      req_payload <= rq;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      cmd_count[rq.command]++;
      sent++;
   endtask

   task automatic idle_cycles(input int n);
      @(negedge clock);
      start <= 1'b0;
      for (int i = 1; i < n; i++) @(negedge clock);
   endtask

   task automatic drain();
      idle_cycles(1);
      while (pending != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 6))
         0, 1: return $urandom;
         2:    return $urandom_range(0, 8 * ONE) - 4 * ONE;
         3:    return $urandom_range(0, 512) - 256;
         4: begin
            case ($urandom_range(0, 5))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return 32'h0;
               3: return 32'h1;
               4: return 32'hffff_ffff;
               default: return ONE;
            endcase
         end
         5:    return $urandom_range(0, 2048) * 32'h8000 - 32'h0200_0000;
         default: return $urandom_range(0, 1) ? 32'h0 : $urandom;
      endcase
   endfunction

   function automatic req_type make_req(input logic [3:0] c, input logic [31:0] ax,
                                        input logic [31:0] ay, input logic [31:0] az,
                                        input logic [31:0] bx, input logic [31:0] by,
                                        input logic [31:0] bz, input logic [31:0] s);
      req_type rq;
      rq.command = c;
      rq.ax = ax; rq.ay = ay; rq.az = az;
      rq.bx = bx; rq.by = by; rq.bz = bz;
      rq.scalar = s;
      return rq;
   endfunction

   initial begin
      req_type rq;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      cycles = 0;
      sent = 0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, each command, zero divisors, ties, zero normalise, unknown codes
      issue(make_req(CMD_ADD, Q_MAX, Q_MIN, ONE, Q_MAX, Q_MIN, 32'hffff_ffff, 0));
      issue(make_req(CMD_SUB, Q_MIN, Q_MAX, 0, Q_MAX, Q_MIN, 0, 0));
      issue(make_req(CMD_MUL, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 0));
      issue(make_req(CMD_MUL, 1, 32'hffff_ffff, 3, 32'h8000, 32'h8000, 32'h8000, 0));
      issue(make_req(CMD_DIV, ONE, 32'hffff_0000, 0, 0, 0, 0, 0));
      issue(make_req(CMD_DIV, Q_MAX, Q_MIN, 1, 1, 1, 32'h2_0000, 0));
      issue(make_req(CMD_DIV, 3 * ONE, 32'hfffd_0000, 1, 2 * ONE, 2 * ONE, 2, 0));
      issue(make_req(CMD_SCALE, Q_MAX, Q_MIN, ONE, 0, 0, 0, Q_MIN));
      issue(make_req(CMD_SCALE, 32'h1_8000, 32'hfffe_8000, 1, 0, 0, 0, 32'h8000));
      issue(make_req(CMD_SDIV, ONE, 32'hffff_0000, 0, 0, 0, 0, 0));
      issue(make_req(CMD_SDIV, Q_MAX, Q_MIN, 7 * ONE, 0, 0, 0, 1));
      issue(make_req(CMD_CROSS, ONE, 0, 0, 0, ONE, 0, 0));
      issue(make_req(CMD_CROSS, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0));
      issue(make_req(CMD_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0));
      issue(make_req(CMD_DOT, ONE, 2 * ONE, 3 * ONE, 32'hffff_0000, ONE, 0, 0));
      issue(make_req(CMD_LEN, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0));
      issue(make_req(CMD_LEN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0));
      issue(make_req(CMD_LENSQ, Q_MAX, 0, 0, 0, 0, 0, 0));
      issue(make_req(CMD_LENSQ, 2 * ONE, 32'hffff_0000, 1, 0, 0, 0, 0));
      issue(make_req(CMD_NORM, 0, 0, 0, ONE, ONE, ONE, ONE));
      issue(make_req(CMD_NORM, 3 * ONE, 32'hfffc_0000, 0, 0, 0, 0, 0));
      issue(make_req(CMD_NORM, 1, 0, 0, 0, 0, 0, 0));
      issue(make_req(4'd11, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      issue(make_req(4'd15, Q_MIN, 1, 1, 1, 1, 1, 1));

      // let the pipeline empty completely before random traffic
      drain();

      // random requests, with an unbroken burst in the middle
      for (int n = 0; n < RANDOM_REQS; n++) begin
         rq = make_req(4'($urandom_range(0, 99) < 95 ? $urandom_range(0, 10)
                                                     : $urandom_range(11, 15)),
                       pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                       pick_word(), pick_word());
         if (!(n >= 250 && n < 400) && $urandom_range(0, 99) < 23)
            idle_cycles($urandom_range(1, 6));
         if (n == 500) drain();
         issue(rq);
      end

      drain();
      repeat (LATENCY + 10) @(negedge clock);

      $display("Sent %0d requests: add %0d sub %0d mul %0d div %0d scale %0d sdiv %0d",
               sent, cmd_count[CMD_ADD], cmd_count[CMD_SUB], cmd_count[CMD_MUL],
               cmd_count[CMD_DIV], cmd_count[CMD_SCALE], cmd_count[CMD_SDIV]);
      $display("cross %0d dot %0d len %0d lensq %0d norm %0d, %0d mismatches",
               cmd_count[CMD_CROSS], cmd_count[CMD_DOT], cmd_count[CMD_LEN],
               cmd_count[CMD_LENSQ], cmd_count[CMD_NORM], errors);
      if (errors == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
